// ----- rtl/cbtf_pkg.sv -----
// Package for the channel burst transmit framer.
// Holds the framing constants and the word-set type passed from framer to emitter.
// No dependencies.
`default_nettype none

package cbtf_pkg;

	localparam int unsigned MAX_WORDS = 5;
	localparam int unsigned WORD_W    = 16;
	localparam int unsigned CNT_W     = 3;

	localparam logic [9:0]  MAX_BURST = 10'd1023;

	localparam logic [15:0] CHAN_FLAG = 16'h0200;
	localparam logic [15:0] EOD_WORD  = 16'h0400;
	localparam logic [15:0] CTL_FLAG  = 16'h0100;

	// All words caused by one input byte, first word in entry 0.
	typedef struct packed {
		logic [CNT_W-1:0]                  count;
		logic [MAX_WORDS-1:0][WORD_W-1:0] words;
	} word_set_t;

endpackage

`default_nettype wire

// ----- rtl/cbtf_framer.sv -----
// Header parser and burst tracker of the channel burst transmit framer.
// Builds the word set for each accepted byte and updates the framing state.
// Depends on cbtf_pkg.
`default_nettype none

module cbtf_framer (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              accept,
	input  wire logic [7:0]        msg_byte,
	input  wire logic              msg_end,
	output cbtf_pkg::word_set_t    set
);

	import cbtf_pkg::*;

	typedef enum logic [3:0] {
		POS_CHAN_LO = 4'b0001,
		POS_CHAN_HI = 4'b0010,
		POS_CTL     = 4'b0100,
		POS_PAYLOAD = 4'b1000
	} pos_t;

	pos_t        pos_q, pos_n;
	logic [7:0]  chan_low_q, chan_low_n;
	logic [15:0] chan_word_q, chan_word_n;
	logic [7:0]  ctl_q, ctl_n;
	logic [9:0]  left_q, left_n;
	logic        open_q, open_n;

	always_comb begin
		logic [CNT_W-1:0] n;
		logic [9:0]       left_v;
		n           = '0;
		set.words   = '0;
		pos_n       = pos_q;
		chan_low_n  = chan_low_q;
		chan_word_n = chan_word_q;
		ctl_n       = ctl_q;
		left_n      = left_q;
		open_n      = open_q;
		left_v      = left_q;
		unique case (pos_q)
			POS_CHAN_LO: begin
				chan_low_n = msg_byte;
				pos_n      = msg_end ? POS_CHAN_LO : POS_CHAN_HI;
				left_n     = MAX_BURST;
				open_n     = 1'b0;
			end
			POS_CHAN_HI: begin
				chan_word_n = CHAN_FLAG | {msg_byte, chan_low_q};
				pos_n       = msg_end ? POS_CHAN_LO : POS_CTL;
				left_n      = MAX_BURST;
				open_n      = 1'b0;
			end
			POS_CTL: begin
				ctl_n  = msg_byte;
				left_n = MAX_BURST;
				open_n = 1'b0;
				if (msg_end) begin
					// Header-only message: channel word, optional control, end of data.
					pos_n = POS_CHAN_LO;
					set.words[n] = chan_word_q;
					n = n + 3'd1;
					if (msg_byte != 8'd0) begin
						set.words[n] = CTL_FLAG | {8'd0, msg_byte};
						n = n + 3'd1;
					end
					set.words[n] = EOD_WORD;
					n = n + 3'd1;
				end else begin
					pos_n = POS_PAYLOAD;
				end
			end
			POS_PAYLOAD: begin
				if (!open_q) begin
					set.words[n] = chan_word_q;
					n = n + 3'd1;
					open_n = 1'b1;
					left_v = MAX_BURST;
				end else if (left_q == 10'd0) begin
					// Burst is full: close it and reopen on the same channel.
					set.words[n] = EOD_WORD;
					n = n + 3'd1;
					set.words[n] = chan_word_q;
					n = n + 3'd1;
					left_v = MAX_BURST;
				end
				set.words[n] = {8'd0, msg_byte};
				n = n + 3'd1;
				if (left_v != 10'd0) begin
					left_v = left_v - 10'd1;
				end
				left_n = left_v;
				if (msg_end) begin
					if (ctl_q != 8'd0) begin
						set.words[n] = CTL_FLAG | {8'd0, ctl_q};
						n = n + 3'd1;
					end
					set.words[n] = EOD_WORD;
					n = n + 3'd1;
					pos_n  = POS_CHAN_LO;
					left_n = MAX_BURST;
					open_n = 1'b0;
				end
			end
			default: begin
				pos_n = POS_CHAN_LO;
			end
		endcase
		set.count = n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= POS_CHAN_LO;
			chan_low_q  <= '0;
			chan_word_q <= '0;
			ctl_q       <= '0;
			left_q      <= MAX_BURST;
			open_q      <= 1'b0;
		end else if (accept) begin
			pos_q       <= pos_n;
			chan_low_q  <= chan_low_n;
			chan_word_q <= chan_word_n;
			ctl_q       <= ctl_n;
			left_q      <= left_n;
			open_q      <= open_n;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/cbtf_emitter.sv -----
// Result register of the channel burst transmit framer.
// Holds one word set and hands its words out one per output item.
// Depends on cbtf_pkg.
`default_nettype none

module cbtf_emitter (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         load,
	input  cbtf_pkg::word_set_t               set,
	output logic                              room,
	output logic                              m_tvalid,
	input  wire logic                         m_tready,
	output logic [cbtf_pkg::WORD_W-1:0]       m_tdata,
	output logic                              m_tlast
);

	import cbtf_pkg::*;

	logic [MAX_WORDS-1:0][WORD_W-1:0] words_q;
	logic [CNT_W-1:0]                 remain_q;
	logic                             take;

	assign m_tvalid = (remain_q != '0);
	assign m_tlast  = (remain_q == CNT_W'(1));
	assign m_tdata  = words_q[0];
	assign take     = m_tvalid && m_tready;
	// A new set may enter when the register is empty or its last word leaves now.
	assign room     = !m_tvalid || (m_tlast && m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			remain_q <= '0;
		end else if (load) begin
			remain_q <= set.count;
		end else if (take) begin
			remain_q <= remain_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			words_q <= set.words;
		end else if (take) begin
			for (int i = 0; i < MAX_WORDS - 1; i++) begin
				words_q[i] <= words_q[i+1];
			end
			words_q[MAX_WORDS-1] <= '0;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/channel_burst_tx_framer_core.sv -----
// Top level of the channel burst transmit framer.
// Instantiates cbtf_framer and cbtf_emitter; depends on cbtf_pkg.
//
//   Channel | Direction | tdata                   | tlast
//   --------+-----------+-------------------------+-------------------------------
//   s_*     | in        | [7:0] msg_byte          | msg_end, last byte of message
//   m_*     | out       | [15:0] fifo_word        | run_last, last word of a byte
//
// A byte is taken when s_tvalid and s_tready meet: the framer turns it and the framing state into a
// set of up to five words, which is stored in the result register at the same edge.
// The result register sends one word per cycle while m_tready is high, so a byte holds the
// output for as many words as it makes (up to five, payload bytes usually
// one); the next byte is taken in the cycle its predecessor's last word leaves, or at
// once when nothing waits.
// Reset (arst_n low, asynchronous) returns the framer to the channel low byte,
// clears the saved header bytes and empties the result register.
`default_nettype none

module channel_burst_tx_framer_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] msg_byte
	input  wire logic        s_tlast,   // msg_end
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [15:0]      m_tdata,   // [15:0] fifo_word
	output logic             m_tlast    // run_last
);

	import cbtf_pkg::*;

	word_set_t set;
	logic      in_acc;
	logic      load;
	logic      room;

	// Bytes that make no words, such as header bytes, only move the framing state.
	assign s_tready = room;
	assign in_acc   = s_tvalid && s_tready;
	assign load     = in_acc && (set.count != '0);

	cbtf_framer u_framer (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (in_acc),
		.msg_byte (s_tdata),
		.msg_end  (s_tlast),
		.set      (set)
	);

	cbtf_emitter u_emitter (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (load),
		.set      (set),
		.room     (room),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

`ifndef NO_ASSERTIONS
	// A byte is never taken while an earlier word set still has words beyond this one.
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && m_tvalid) |-> (m_tlast && m_tready))
		else $error("byte accepted while result words were pending");

	// After the last word leaves with nothing loaded, the output goes idle.
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && m_tlast && !load) |=> !m_tvalid)
		else $error("output stayed valid after the last word of a set");

	// A loaded set never holds more words than the result register can send.
	a_set_size: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> (set.count <= CNT_W'(MAX_WORDS)))
		else $error("word set larger than the result register");
`endif

endmodule

`default_nettype wire

// ----- sim/tb_channel_burst_tx_framer_core.sv -----
// Self-checking testbench for channel_burst_tx_framer_core.
// Drives message bytes with random gaps and predicts every FIFO word;
// depends on cbtf_pkg and the framer RTL.
`default_nettype none

module tb_channel_burst_tx_framer_core;

	import cbtf_pkg::*;

	// Watchdog limit in cycles. The slowest correct run is roughly fifteen hundred
	// items, each at most five words, with both sides stalling about a third of
	// the time; this is many times that.
	localparam int unsigned CYCLE_LIMIT = 250000;

	// Where the framer stands inside the current message.
	typedef enum logic [1:0] {
		HDR_CHAN_LO,
		HDR_CHAN_HI,
		HDR_CTL,
		HDR_PAYLOAD
	} hdr_pos_t;

	// One byte waiting to be sent. When hold is set, the sender does not offer
	// the byte until every word predicted so far has come out.
	typedef struct {
		logic [7:0] data;
		logic       fin;
		bit         hold;
	} msg_byte_t;

	// One predicted FIFO word and its end-of-byte flag.
	typedef struct packed {
		logic [15:0] word;
		logic        last;
	} fifo_word_t;

	logic        clk;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata  = 8'h00;  // [7:0] msg_byte
	logic        s_tlast  = 1'b0;   // msg_end
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;           // [15:0] fifo_word
	logic        m_tlast;           // run_last

	msg_byte_t   tx_byte_q[$];
	fifo_word_t  fifo_word_exp_q[$];
	logic [15:0] byte_words[$];     // words caused by the byte being predicted

	// Predicted framing state.
	hdr_pos_t    hdr_pos    = HDR_CHAN_LO;
	logic [7:0]  chan_lo    = 8'h00;
	logic [15:0] chan_wd    = 16'h0000;
	logic [7:0]  ctl_sv     = 8'h00;
	logic [9:0]  burst_rem  = MAX_BURST;
	logic        burst_sent = 1'b0;

	int unsigned cyc        = 0;
	int unsigned err_count  = 0;
	msg_byte_t   next_byte;
	fifo_word_t  got_exp;

	// For the first stretch of the run, after warm-up, neither side stalls at random.
	wire calm = (cyc >= 300) && (cyc < 2300);

	channel_burst_tx_framer_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// ------------------------------------------------------------------
	// Prediction
	// ------------------------------------------------------------------

	// Back to the start of a message; the saved header bytes are kept.
	function automatic void framer_restart();
		hdr_pos    = HDR_CHAN_LO;
		burst_rem  = MAX_BURST;
		burst_sent = 1'b0;
	endfunction

	// End of message: the control word only when the control byte is nonzero,
	// then the end-of-data word in every case.
	function automatic void close_message();
		if (ctl_sv != 8'h00)
			byte_words.push_back(CTL_FLAG | {8'h00, ctl_sv});
		byte_words.push_back(EOD_WORD);
		framer_restart();
	endfunction

	// Works out the words that one accepted byte causes and queues them, with
	// the last of them flagged.
	function automatic void frame_byte(input logic [7:0] b, input logic fin);
		byte_words.delete();
		case (hdr_pos)
			HDR_CHAN_LO: begin
				chan_lo = b;
				// A message ending here is too short and is dropped.
				if (fin)
					framer_restart();
				else
					hdr_pos = HDR_CHAN_HI;
			end
			HDR_CHAN_HI: begin
				chan_wd = CHAN_FLAG | {b, chan_lo};
				if (fin)
					framer_restart();
				else
					hdr_pos = HDR_CTL;
			end
			HDR_CTL: begin
				ctl_sv = b;
				if (fin) begin
					// Header-only message: the channel word still goes out.
					byte_words.push_back(chan_wd);
					close_message();
				end else begin
					hdr_pos    = HDR_PAYLOAD;
					burst_sent = 1'b0;
					burst_rem  = MAX_BURST;
				end
			end
			default: begin
				if (!burst_sent) begin
					byte_words.push_back(chan_wd);
					burst_sent = 1'b1;
					burst_rem  = MAX_BURST;
				end else if (burst_rem == 10'd0) begin
					// The burst is full: close it and open a new one on the
					// same channel before this byte.
					byte_words.push_back(EOD_WORD);
					byte_words.push_back(chan_wd);
					burst_rem = MAX_BURST;
				end
				byte_words.push_back({8'h00, b});
				if (burst_rem != 10'd0)
					burst_rem = burst_rem - 10'd1;
				if (fin)
					close_message();
			end
		endcase
		foreach (byte_words[i])
			fifo_word_exp_q.push_back('{word: byte_words[i],
				last: (i == byte_words.size() - 1)});
	endfunction

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------

	function automatic void queue_byte(input logic [7:0] data, input logic fin,
			input bit hold = 1'b0);
		tx_byte_q.push_back('{data: data, fin: fin, hold: hold});
	endfunction

	// A message of n_bytes bytes in all: random channel bytes, the given
	// control byte at position two, and random payload after it.
	function automatic void queue_message(input int n_bytes, input logic [7:0] ctl,
			input bit hold);
		logic [7:0] data;
		for (int i = 0; i < n_bytes; i++) begin
			data = (i == 2) ? ctl : 8'($urandom);
			queue_byte(data, i == n_bytes - 1, hold && (i == 0));
		end
	endfunction

	// Sender: a new byte is offered once the current one is taken. Bytes marked
	// hold wait until nothing is outstanding; a byte accepted at this very edge
	// still counts as outstanding, since its words may not be queued yet.
	always @(posedge clk) begin
		if (arst_n && (!s_tvalid || s_tready)) begin
			if (tx_byte_q.size() != 0 && (calm || $urandom_range(99) >= 37) &&
			    !(tx_byte_q[0].hold && (fifo_word_exp_q.size() != 0 || s_tvalid))) begin
				next_byte = tx_byte_q.pop_front();
				s_tvalid <= 1'b1;
				s_tdata  <= next_byte.data;
				s_tlast  <= next_byte.fin;
			end else begin
				s_tvalid <= 1'b0;
				s_tdata  <= 8'($urandom);
				s_tlast  <= 1'($urandom);
			end
		end
	end

	// Receiver stalls at random, except during the calm stretch.
	always @(posedge clk) begin
		if (arst_n)
			m_tready <= calm || ($urandom_range(99) >= 37);
	end

	// ------------------------------------------------------------------
	// Checking
	// ------------------------------------------------------------------

	// Both handshakes are sampled at the rising edge. A word leaving at this
	// edge always belongs to an older byte, so the order of the two steps does
	// not matter.
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				frame_byte(s_tdata, s_tlast);
			if (m_tvalid && m_tready) begin
				if (fifo_word_exp_q.size() == 0) begin
					$error("fifo_word: none expected, got %h (run_last %b)",
						m_tdata, m_tlast);
					err_count++;
				end else begin
					got_exp = fifo_word_exp_q.pop_front();
					if (m_tdata !== got_exp.word) begin
						$error("fifo_word: expected %h, got %h", got_exp.word, m_tdata);
						err_count++;
					end
					if (m_tlast !== got_exp.last) begin
						$error("run_last: expected %b, got %b", got_exp.last, m_tlast);
						err_count++;
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cyc <= cyc + 1;
		if (cyc >= CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------

	initial begin
		int unsigned n_items;
		int          n_bytes;
		int          r;
		logic [7:0]  ctl;
		bit          long_done;

		// Directed part.
		// Message ending on the channel low byte, then on the channel high byte.
		queue_byte(8'hFF, 1'b1);
		queue_byte(8'h00, 1'b0);
		queue_byte(8'hFF, 1'b1);
		// Header-only message, all-ones channel, zero control: channel and EOD.
		queue_byte(8'hFF, 1'b0);
		queue_byte(8'hFF, 1'b0);
		queue_byte(8'h00, 1'b1);
		// Header-only message, zero channel, all-ones control: three words.
		queue_byte(8'h00, 1'b0);
		queue_byte(8'h00, 1'b0);
		queue_byte(8'hFF, 1'b1);
		// Payload with nonzero control, extreme payload values.
		queue_byte(8'h12, 1'b0);
		queue_byte(8'h34, 1'b0);
		queue_byte(8'h80, 1'b0);
		queue_byte(8'h00, 1'b0);
		queue_byte(8'hFF, 1'b1);
		// Single payload byte with zero control.
		queue_byte(8'hA5, 1'b0);
		queue_byte(8'h5A, 1'b0);
		queue_byte(8'h00, 1'b0);
		queue_byte(8'h01, 1'b1);
		n_items = 18;

		// Random part: mostly well-formed messages with random content, some
		// too short to frame, some header-only. Roughly midway, one long
		// message whose payload first exactly fills a burst and whose last byte
		// then rolls the burst over under a nonzero control byte (the five-word
		// case).
		long_done = 1'b0;
		while (n_items < 418) begin
			r = $urandom_range(99);
			if (r < 10)
				n_bytes = $urandom_range(1, 2);
			else if (r < 25)
				n_bytes = 3;
			else if (r < 90)
				n_bytes = 3 + $urandom_range(1, 6);
			else
				n_bytes = 3 + $urandom_range(7, 30);
			ctl = ($urandom_range(99) < 35) ? 8'h00 : 8'($urandom_range(1, 255));
			queue_message(n_bytes, ctl, (n_items == 18) || ($urandom_range(99) < 5));
			n_items += n_bytes;
			if (!long_done && n_items >= 200) begin
				queue_message(4 + int'(MAX_BURST), 8'hC3, 1'b0);
				long_done = 1'b1;
			end
		end

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Wait for every byte to be taken and every word to come out, then
		// keep the clock running so that any stray word can show.
		while (tx_byte_q.size() != 0 || s_tvalid)
			@(posedge clk);
		while (fifo_word_exp_q.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		if (err_count == 0 && fifo_word_exp_q.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

`default_nettype wire

// ----- channel_burst_tx_framer_core.f -----
rtl/cbtf_pkg.sv
rtl/cbtf_framer.sv
rtl/cbtf_emitter.sv
rtl/channel_burst_tx_framer_core.sv
sim/tb_channel_burst_tx_framer_core.sv
